[rtl/dctn_pkg.sv]
`timescale 1ns / 1ps
// Shared types and constants of the DC-tracked waveform normalizer.
// Used by the channel interfaces, the divider and the top level.
package dctn_pkg;

  // Field widths of the sample and result channels
  localparam int RAW_W   = 24;
  localparam int NORM_W  = 16;
  localparam int SLOT_W  = 7;
  localparam int FILL_W  = 8;
  localparam int DC_W    = 24;

  // DC tracking shift and normalization scale (4096 = 1 << 12)
  localparam int DC_SHIFT   = 5;
  localparam int SCALE_BITS = 12;

  // Quotient magnitude kept by the divider: 16 bits plus one guard bit
  localparam int QUO_W = NORM_W + 1;

  // Saturation limits of the normalized value
  localparam logic signed [NORM_W-1:0] NORM_MAX = 16'sh7FFF;
  localparam logic signed [NORM_W-1:0] NORM_MIN = 16'sh8000;
  localparam logic [QUO_W-1:0] QUO_POS_LIM = 17'd32767;
  localparam logic [QUO_W-1:0] QUO_NEG_LIM = 17'd32768;

  // Request commands
  localparam logic CMD_ADD   = 1'b0;
  localparam logic CMD_CLEAR = 1'b1;

  // Sequencer states of the top level
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIFF,
    ST_STEP,
    ST_AC,
    ST_LOAD,
    ST_DIV,
    ST_DONE
  } state_t;

  // Status returned by the divider
  typedef struct packed {
    logic             done;
    logic             ovf;
    logic [QUO_W-1:0] quo;
  } div_stat_t;

endpackage

[rtl/dctn_if.sv]
`timescale 1ns / 1ps
// Valid/ready channel interfaces for sample requests and normalized results.
// Depends on dctn_pkg for the field widths.
interface dctn_sample_if;
  logic                         valid;
  logic                         ready;
  logic                         cmd;
  logic                         channel;
  logic [dctn_pkg::RAW_W-1:0]   raw_sample;

  modport source (output valid, cmd, channel, raw_sample, input ready);
  modport sink   (input valid, cmd, channel, raw_sample, output ready);
endinterface

interface dctn_result_if;
  logic                              valid;
  logic                              ready;
  logic                              out_channel;
  logic signed [dctn_pkg::NORM_W-1:0] norm_value;
  logic [dctn_pkg::SLOT_W-1:0]       slot_index;
  logic [dctn_pkg::FILL_W-1:0]       fill_count;
  logic [dctn_pkg::DC_W-1:0]         dc_level;

  modport source (output valid, out_channel, norm_value, slot_index, fill_count, dc_level,
                  input ready);
  modport sink   (input valid, out_channel, norm_value, slot_index, fill_count, dc_level,
                  output ready);
endinterface

[rtl/dctn_div.sv]
`timescale 1ns / 1ps
// Bit-serial restoring divider: (mag << 12) / den, one dividend bit per cycle.
// Keeps a 17-bit quotient with a sticky overflow flag; depends on dctn_pkg.
module dctn_div #(
  parameter int XW = 24
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  logic [XW-1:0]       mag,
  input  logic [XW-1:0]       den,
  output dctn_pkg::div_stat_t stat
);

  localparam int NB = XW + dctn_pkg::SCALE_BITS;
  localparam int CNT_W = $clog2(NB + 1);

  logic                       busy;
  logic                       done;
  logic [CNT_W-1:0]           cnt;
  logic [NB-1:0]              num_sr;
  logic [XW-1:0]              rem;
  logic [XW-1:0]              den_q;
  logic [dctn_pkg::QUO_W-1:0] quo;
  logic                       ovf;

  logic [XW:0]                rem_sh;
  logic                       ge;
  logic [XW:0]                rem_sub;

  // Shift in the next dividend bit and trial-subtract the divisor
  always_comb begin
    rem_sh  = {rem, num_sr[NB-1]};
    ge      = rem_sh >= {1'b0, den_q};
    rem_sub = rem_sh - {1'b0, den_q};
  end

  // Sequence control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CNT_W'(NB);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Datapath: one quotient bit per cycle, overflow sticks once a bit leaves the top
  always_ff @(posedge clk) begin
    if (start) begin
      num_sr <= {mag, {dctn_pkg::SCALE_BITS{1'b0}}};
      den_q  <= den;
      rem    <= '0;
      quo    <= '0;
      ovf    <= 1'b0;
    end else if (busy) begin
      num_sr <= {num_sr[NB-2:0], 1'b0};
      rem    <= ge ? rem_sub[XW-1:0] : rem_sh[XW-1:0];
      quo    <= {quo[dctn_pkg::QUO_W-2:0], ge};
      ovf    <= ovf | quo[dctn_pkg::QUO_W-1];
    end
  end

  assign stat.done = done;
  assign stat.ovf  = ovf;
  assign stat.quo  = quo;

endmodule

[rtl/dc_tracked_waveform_normalizer.sv]
`timescale 1ns / 1ps
// Top level of the two-channel DC-tracked waveform normalizer.
// Depends on dctn_pkg, dctn_sample_if, dctn_result_if and dctn_div.
//
// Each request either adds a sample to the infrared or red channel or clears both channels.
// Let XW be SAMPLE_BITS capped at the 24-bit sample field. An added sample is accepted in
// the idle state and then passes through DC tracking and AC extraction (DIFF, STEP, AC),
// a load state, the bit-serial divider that forms (sample - dc) * 4096 / dc over an XW + 12
// bit dividend, the divider's completion flag, and the done state that saturates and
// registers the result. A clear request gives no result.
// One sample is worked on at a time; the next request is taken while a finished
// result still waits in the output register. A result that is not taken holds the
// finished sample, and with it the input, until the output register is free.
module dc_tracked_waveform_normalizer #(
  parameter int RING_DEPTH  = 128,
  parameter int SAMPLE_BITS = 24
) (
  input  logic          clk,
  input  logic          rst,
  dctn_sample_if.sink   sample,
  dctn_result_if.source result
);

  localparam int XW = (SAMPLE_BITS < dctn_pkg::RAW_W) ? SAMPLE_BITS : dctn_pkg::RAW_W;
  localparam int PW = $clog2(RING_DEPTH);
  localparam int CW = $clog2(RING_DEPTH + 1);

  // Per-channel tracking state
  logic [XW-1:0] dc_track   [2];
  logic [PW-1:0] ring_pos   [2];
  logic [CW-1:0] held_count [2];

  // Work registers of the sample in flight
  dctn_pkg::state_t state, state_next;
  logic             ch_q;
  logic [XW-1:0]    x_q;
  logic [XW-1:0]    dc_old;
  logic [XW-1:0]    absd;
  logic             up;
  logic [XW-1:0]    dc_new;
  logic [XW-1:0]    mag;
  logic             neg;
  logic [PW-1:0]    slot_q;
  logic [CW-1:0]    cnt_q;

  // Output register
  logic                               res_valid;
  logic                               res_channel;
  logic signed [dctn_pkg::NORM_W-1:0] res_norm;
  logic [dctn_pkg::SLOT_W-1:0]        res_slot;
  logic [dctn_pkg::FILL_W-1:0]        res_fill;
  logic [dctn_pkg::DC_W-1:0]          res_dc;

  // Control decodes
  logic in_ready;
  logic div_start;
  logic out_load;
  logic in_fire;

  // Step and normalization logic
  logic [XW-1:0]                      step;
  logic [XW-1:0]                      dc_step;
  logic [PW-1:0]                      slot_cur;
  logic [CW-1:0]                      held_cur;
  logic signed [dctn_pkg::NORM_W-1:0] norm;
  logic [dctn_pkg::QUO_W-1:0]         quo_neg;
  logic [31:0]                        slot_ext;
  logic [31:0]                        fill_ext;
  logic [31:0]                        dc_ext;
  dctn_pkg::div_stat_t                stat;

  dctn_div #(
    .XW (XW)
  ) u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .mag   (mag),
    .den   (dc_new),
    .stat  (stat)
  );

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      dctn_pkg::ST_IDLE: begin
        if (sample.valid && sample.cmd == dctn_pkg::CMD_ADD) state_next = dctn_pkg::ST_DIFF;
      end
      dctn_pkg::ST_DIFF: state_next = dctn_pkg::ST_STEP;
      dctn_pkg::ST_STEP: state_next = dctn_pkg::ST_AC;
      dctn_pkg::ST_AC:   state_next = dctn_pkg::ST_LOAD;
      dctn_pkg::ST_LOAD: state_next = dctn_pkg::ST_DIV;
      dctn_pkg::ST_DIV: begin
        if (stat.done) state_next = dctn_pkg::ST_DONE;
      end
      dctn_pkg::ST_DONE: begin
        if (!res_valid || result.ready) state_next = dctn_pkg::ST_IDLE;
      end
      default: state_next = dctn_pkg::ST_IDLE;
    endcase
  end

  // Control outputs
  always_comb begin
    in_ready  = 1'b0;
    div_start = 1'b0;
    out_load  = 1'b0;
    unique case (state)
      dctn_pkg::ST_IDLE: in_ready  = 1'b1;
      dctn_pkg::ST_LOAD: div_start = 1'b1;
      dctn_pkg::ST_DONE: out_load  = !res_valid || result.ready;
      default: ;
    endcase
  end

  assign in_fire = sample.valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) state <= dctn_pkg::ST_IDLE;
    else     state <= state_next;
  end

  // DC step: |x - dc| >> 5, at least 1
  always_comb begin
    step = absd >> dctn_pkg::DC_SHIFT;
    if (step == '0) step = XW'(1);
    dc_step = up ? (dc_old + step) : (dc_old - step);
  end

  assign slot_cur = ring_pos[ch_q];
  assign held_cur = held_count[ch_q];

  // Per-channel state: clear on reset or clear request, advance in the step cycle
  always_ff @(posedge clk) begin
    if (rst || (in_fire && sample.cmd == dctn_pkg::CMD_CLEAR)) begin
      for (int i = 0; i < 2; i++) begin
        dc_track[i]   <= '0;
        ring_pos[i]   <= '0;
        held_count[i] <= '0;
      end
    end else if (state == dctn_pkg::ST_STEP) begin
      if (dc_old == '0)      dc_track[ch_q] <= x_q;
      else if (absd != '0)   dc_track[ch_q] <= dc_step;
      ring_pos[ch_q] <= (slot_cur == PW'(RING_DEPTH - 1)) ? '0 : slot_cur + 1'b1;
      if (held_cur < CW'(RING_DEPTH)) held_count[ch_q] <= held_cur + 1'b1;
    end
  end

  // Work registers
  always_ff @(posedge clk) begin
    unique case (state)
      dctn_pkg::ST_IDLE: begin
        ch_q <= sample.channel;
        x_q  <= sample.raw_sample[XW-1:0];
      end
      dctn_pkg::ST_DIFF: begin
        dc_old <= dc_track[ch_q];
        up     <= x_q > dc_track[ch_q];
        absd   <= (x_q > dc_track[ch_q]) ? (x_q - dc_track[ch_q]) : (dc_track[ch_q] - x_q);
      end
      dctn_pkg::ST_STEP: begin
        if (dc_old == '0)    dc_new <= x_q;
        else if (absd == '0) dc_new <= dc_old;
        else                 dc_new <= dc_step;
        slot_q <= slot_cur;
        cnt_q  <= (held_cur < CW'(RING_DEPTH)) ? held_cur + 1'b1 : held_cur;
      end
      dctn_pkg::ST_AC: begin
        neg <= x_q < dc_new;
        mag <= (x_q < dc_new) ? (dc_new - x_q) : (x_q - dc_new);
      end
      default: ;
    endcase
  end

  // Saturate the signed quotient to 16 bits; zero DC gives zero
  always_comb begin
    quo_neg = -stat.quo;
    if (dc_new == '0) begin
      norm = '0;
    end else if (neg) begin
      norm = (stat.ovf || stat.quo > dctn_pkg::QUO_NEG_LIM) ? dctn_pkg::NORM_MIN
                                                             : quo_neg[dctn_pkg::NORM_W-1:0];
    end else begin
      norm = (stat.ovf || stat.quo > dctn_pkg::QUO_POS_LIM) ? dctn_pkg::NORM_MAX
                                                             : stat.quo[dctn_pkg::NORM_W-1:0];
    end
    slot_ext = 32'(slot_q);
    fill_ext = 32'(cnt_q);
    dc_ext   = 32'(dc_new);
  end

  // Output register: hold until taken, load when free
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (out_load) begin
      res_valid <= 1'b1;
    end else if (result.ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      res_channel <= ch_q;
      res_norm    <= norm;
      res_slot    <= slot_ext[dctn_pkg::SLOT_W-1:0];
      res_fill    <= fill_ext[dctn_pkg::FILL_W-1:0];
      res_dc      <= dc_ext[dctn_pkg::DC_W-1:0];
    end
  end

  assign sample.ready       = in_ready;
  assign result.valid       = res_valid;
  assign result.out_channel = res_channel;
  assign result.norm_value  = res_norm;
  assign result.slot_index  = res_slot;
  assign result.fill_count  = res_fill;
  assign result.dc_level    = res_dc;

endmodule
